[hdl/usd_pkg.sv]
// ----------------------------------------------------------------------------
// usd_pkg
// Types and constants shared by the UTF-8 stream decoder and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package usd_pkg;

	localparam int CpWidth = 21;

	localparam logic [CpWidth-1:0] REPLACEMENT_CP = 21'h00FFFD;
	localparam logic [CpWidth-1:0] GLYPH_I_CP     = 21'h00026A;
	localparam logic [CpWidth-1:0] GLYPH_EPS_CP   = 21'h00025B;

	localparam logic [1:0] GLYPH_FONT = 2'd0;
	localparam logic [1:0] GLYPH_I    = 2'd1;
	localparam logic [1:0] GLYPH_EPS  = 2'd2;

	// classification of a byte seen where a new sequence may start
	typedef enum logic [2:0] {
		LEAD_ASCII,
		LEAD_TWO,
		LEAD_THREE,
		LEAD_FOUR,
		LEAD_BAD
	} lead_t;

	// pending multi-byte sequence
	typedef struct packed {
		logic [2:0]         seq_len;
		logic [1:0]         held;
		logic [CpWidth-1:0] pc;
	} seq_state_t;

	typedef struct packed {
		logic [CpWidth-1:0] cp;
		logic [2:0]         count;
		logic               malformed;
		logic [1:0]         glyph;
	} result_t;

	// results caused by one input word: rep replacements, then optionally fin
	typedef struct packed {
		logic [2:0] rep;
		logic       fin_valid;
		result_t    fin;
	} job_t;

	function automatic logic [1:0] glyph_of(input logic [CpWidth-1:0] cp);
		logic [1:0] sel;
		sel = GLYPH_FONT;
		if (cp == GLYPH_I_CP)
			sel = GLYPH_I;
		else if (cp == GLYPH_EPS_CP)
			sel = GLYPH_EPS;
		return sel;
	endfunction

endpackage

`default_nettype wire

[hdl/utf8_stream_decoder.sv]
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// UTF-8 byte stream to code point decoder with malformed-byte replacement.
// ----------------------------------------------------------------------------
// Takes one byte per cycle and gives one code point word per cycle while the
// output is not stalled. A byte that causes at most one result is then taken
// in every cycle; a byte that causes k results (a broken or unfinished
// sequence flushed as U+FFFD replacements, up to four) holds the input side
// until its results have drained, because the single result register drains
// one word per cycle. Each result passes through the job register and then the
// result register. Bytes that only extend a pending sequence give no result.
`default_nettype none

module utf8_stream_decoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  text_byte,
	input  wire logic        end_of_text,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [20:0]      code_point,
	output logic [2:0]       byte_count,
	output logic             malformed,
	output logic [1:0]       glyph_select,
	output logic             last_of_run
);
	import usd_pkg::*;

	seq_state_t state_q;
	seq_state_t state_nxt;
	job_t       job_dec;
	job_t       job_s1;
	result_t    res_s2;
	logic       last_s2;
	logic       valid_s2;

	logic job_busy;
	logic job_single;
	logic out_free;
	logic accept;

	usd_decode u_decode (
		.text_byte  (text_byte),
		.end_of_text(end_of_text),
		.st         (state_q),
		.nxt        (state_nxt),
		.job        (job_dec)
	);

	assign job_busy   = job_s1.rep != 3'd0 || job_s1.fin_valid;
	assign job_single = (job_s1.rep == 3'd1 && !job_s1.fin_valid) ||
		(job_s1.rep == 3'd0 && job_s1.fin_valid);
	assign out_free   = !valid_s2 || !out_stall;
	// take a new word once the pending one hands over its last result
	assign in_stall   = job_busy && !(job_single && out_free);
	assign accept     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= '0;
			job_s1   <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (out_free) begin
				valid_s2 <= job_busy;
			end
			// a new word only lands when the pending one is done or hands over
			if (accept) begin
				job_s1  <= job_dec;
				state_q <= state_nxt;
			end else if (out_free) begin
				if (job_s1.rep != 3'd0) begin
					job_s1.rep <= job_s1.rep - 3'd1;
				end else if (job_s1.fin_valid) begin
					job_s1.fin_valid <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && job_busy) begin
			if (job_s1.rep != 3'd0) begin
				res_s2  <= '{cp: REPLACEMENT_CP, count: 3'd1, malformed: 1'b1,
					glyph: GLYPH_FONT};
				last_s2 <= job_s1.rep == 3'd1 && !job_s1.fin_valid;
			end else begin
				res_s2  <= job_s1.fin;
				last_s2 <= 1'b1;
			end
		end
	end

	assign out_valid    = valid_s2;
	assign code_point   = res_s2.cp;
	assign byte_count   = res_s2.count;
	assign malformed    = res_s2.malformed;
	assign glyph_select = res_s2.glyph;
	assign last_of_run  = last_s2;

endmodule

`default_nettype wire

[hdl/usd_decode.sv]
// ----------------------------------------------------------------------------
// usd_decode
// Combinational decode of one byte against the pending sequence: gives the
// next sequence state and the list of results the byte causes.
// ----------------------------------------------------------------------------
`default_nettype none

module usd_decode (
	input  wire logic [7:0]          text_byte,
	input  wire logic                end_of_text,
	input  wire usd_pkg::seq_state_t st,
	output usd_pkg::seq_state_t      nxt,
	output usd_pkg::job_t            job
);
	import usd_pkg::*;

	logic               pend;
	logic               cont;
	logic [2:0]         held_inc;
	logic [CpWidth-1:0] pc_shift;
	lead_t              lead;
	result_t            rep_res;

	assign pend     = st.seq_len != 3'd0;
	assign cont     = text_byte[7:6] == 2'b10;
	assign held_inc = {1'b0, st.held} + 3'd1;
	assign pc_shift = {st.pc[CpWidth-7:0], text_byte[5:0]};
	assign rep_res  = '{cp: REPLACEMENT_CP, count: 3'd1, malformed: 1'b1, glyph: GLYPH_FONT};

	always_comb begin
		priority if (!text_byte[7])
			lead = LEAD_ASCII;
		else if (text_byte[7:5] == 3'b110)
			lead = LEAD_TWO;
		else if (text_byte[7:4] == 4'b1110)
			lead = LEAD_THREE;
		else if (text_byte[7:3] == 5'b11110)
			lead = LEAD_FOUR;
		else
			lead = LEAD_BAD;
	end

	always_comb begin
		nxt = st;
		job = '0;
		if (pend && cont) begin
			if (held_inc >= st.seq_len) begin
				job.fin_valid = 1'b1;
				job.fin = '{cp: pc_shift, count: st.seq_len, malformed: 1'b0,
					glyph: glyph_of(pc_shift)};
				nxt = '0;
			end else if (end_of_text) begin
				job.rep = held_inc;
				nxt = '0;
			end else begin
				nxt.held = held_inc[1:0];
				nxt.pc   = pc_shift;
			end
		end else begin
			// broken sequence: every held byte becomes a replacement
			job.rep = pend ? {1'b0, st.held} : 3'd0;
			nxt = '0;
			unique case (lead)
				LEAD_ASCII: begin
					job.fin_valid = 1'b1;
					job.fin = '{cp: {13'd0, text_byte}, count: 3'd1, malformed: 1'b0,
						glyph: GLYPH_FONT};
				end
				LEAD_TWO: begin
					nxt = '{seq_len: 3'd2, held: 2'd1, pc: {16'd0, text_byte[4:0]}};
				end
				LEAD_THREE: begin
					nxt = '{seq_len: 3'd3, held: 2'd1, pc: {17'd0, text_byte[3:0]}};
				end
				LEAD_FOUR: begin
					nxt = '{seq_len: 3'd4, held: 2'd1, pc: {18'd0, text_byte[2:0]}};
				end
				default: begin
					job.fin_valid = 1'b1;
					job.fin = rep_res;
				end
			endcase
			// text ends right after a new lead
			if (end_of_text && nxt.seq_len != 3'd0) begin
				job.rep = job.rep + 3'd1;
				nxt = '0;
			end
		end
	end

endmodule

`default_nettype wire

[hdl/usd_checker.sv]
// ----------------------------------------------------------------------------
// usd_checker
// Port-level checks on the decoder output stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module usd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [20:0] code_point,
	input wire logic [2:0]  byte_count,
	input wire logic        malformed,
	input wire logic [1:0]  glyph_select,
	input wire logic        last_of_run
);
	import usd_pkg::*;

	// stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(code_point) &&
		$stable(byte_count) && $stable(malformed) && $stable(glyph_select) &&
		$stable(last_of_run))
		else $error("output word changed while stalled");

	// replacements are single-byte U+FFFD with the font glyph
	a_repl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && malformed |-> code_point == REPLACEMENT_CP &&
		byte_count == 3'd1 && glyph_select == GLYPH_FONT)
		else $error("malformed word with bad fields");

	// glyph tag agrees with the code point
	a_glyph: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (glyph_select == GLYPH_I && code_point == GLYPH_I_CP) ||
		(glyph_select == GLYPH_EPS && code_point == GLYPH_EPS_CP) ||
		(glyph_select == GLYPH_FONT && code_point != GLYPH_I_CP &&
		code_point != GLYPH_EPS_CP))
		else $error("glyph tag does not match code point");

	// a decoded point has a byte count of 1 to 4; one of 1 to 3 bytes fits the range its length allows
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !malformed |-> (byte_count == 3'd1 && code_point < 21'h80) ||
		(byte_count == 3'd2 && code_point < 21'h800) ||
		(byte_count == 3'd3 && code_point < 21'h10000) ||
		(byte_count == 3'd4))
		else $error("byte count does not fit code point");

endmodule

bind utf8_stream_decoder usd_checker u_usd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.code_point  (code_point),
	.byte_count  (byte_count),
	.malformed   (malformed),
	.glyph_select(glyph_select),
	.last_of_run (last_of_run)
);

`default_nettype wire
